[src/i2cms_pkg.sv]
// ----------------------------------------------------------------------------
// I2C master transfer sequencer: shared definitions
// Buffer sizing, request and bus status codes, the transfer state type and
// the structures that pass between the sequencer modules.
// ----------------------------------------------------------------------------
package i2cms_pkg;

  // Transfer buffer depth, address byte included.
  localparam int BUFFER_DEPTH = 16;
  localparam int ADDR_W       = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  // Position counter must be able to hold the depth itself.
  localparam int POS_W        = $clog2(BUFFER_DEPTH + 1);

  localparam logic [POS_W-1:0] POS_DEPTH = POS_W'(BUFFER_DEPTH);
  localparam logic [7:0]       LEN_CAP   = 8'(BUFFER_DEPTH);

  // Request types.
  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_EVENT = 2'd2;
  localparam logic [1:0] REQ_READ  = 2'd3;

  // Start modes.
  localparam logic [1:0] MODE_STOP     = 2'd1;
  localparam logic [1:0] MODE_AUTOREAD = 2'd2;

  // Bus status codes, low three bits masked off.
  localparam logic [7:0] STATUS_MASK     = 8'hF8;
  localparam logic [7:0] BS_START        = 8'h08;
  localparam logic [7:0] BS_RESTART      = 8'h10;
  localparam logic [7:0] BS_MT_SLA_ACK   = 8'h18;
  localparam logic [7:0] BS_MT_SLA_NACK  = 8'h20;
  localparam logic [7:0] BS_MT_DATA_ACK  = 8'h28;
  localparam logic [7:0] BS_MT_DATA_NACK = 8'h30;
  localparam logic [7:0] BS_ARB_LOST     = 8'h38;
  localparam logic [7:0] BS_MR_SLA_ACK   = 8'h40;
  localparam logic [7:0] BS_MR_SLA_NACK  = 8'h48;
  localparam logic [7:0] BS_MR_DATA_ACK  = 8'h50;
  localparam logic [7:0] BS_MR_DATA_NACK = 8'h58;

  // Read bit of the address byte.
  localparam logic [7:0] READ_BIT = 8'h01;

  typedef enum logic [2:0] {
    TS_IDLE     = 3'd0,
    TS_NOSTOP   = 3'd1,
    TS_STOP     = 3'd2,
    TS_AUTOREAD = 3'd3,
    TS_NAK_ADDR = 3'd4,
    TS_NAK_DATA = 3'd5,
    TS_ARB_LOST = 3'd6,
    TS_FATAL    = 3'd7
  } state_t;

  // One request as held in the input register.
  typedef struct packed {
    logic [1:0] req_type;
    logic [3:0] index;
    logic [7:0] data_byte;
    logic [7:0] bus_status;
    logic [1:0] mode;
    logic [7:0] length;
  } req_item_t;

  // Buffer write port.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } buf_wr_t;

  // One result as held in the output register.
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       send_start;
    logic       send_stop;
    logic       ack_next;
    logic       irq_enabled;
    logic       bus_enabled;
    state_t     transfer_state;
    logic [7:0] last_status;
    logic [7:0] read_byte;
  } step_result_t;

endpackage

[src/i2c_master_transfer_sequencer_core.sv]
// ----------------------------------------------------------------------------
// I2C master transfer sequencer: top level
// Input register, step engine with its byte buffer, and result register.
// ----------------------------------------------------------------------------
// Each request (buffer load, transfer start, bus status event or buffer read)
// produces exactly one result. A request is registered on entry, worked out
// combinationally against the transfer state and registered again on exit,
// so the block takes one request every clock cycle while the result side
// does not stall. A result is presented in the cycle after the engine works
// out its request and is held until the result side takes it. The input
// stalls only while both the input and the result register are full and
// the result side stalls. The byte buffer comes out of reset undefined: bytes
// must be loaded before they are transmitted or read back.
module i2c_master_transfer_sequencer_core (
  input  logic       clk,
  input  logic       rst,
  // Request channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] req_type,
  input  logic [3:0] index,
  input  logic [7:0] data_byte,
  input  logic [7:0] bus_status,
  input  logic [1:0] mode,
  input  logic [7:0] length,
  // Result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] tx_byte,
  output logic       tx_valid,
  output logic       send_start,
  output logic       send_stop,
  output logic       ack_next,
  output logic       irq_enabled,
  output logic       bus_enabled,
  output logic [2:0] transfer_state,
  output logic [7:0] last_status,
  output logic [7:0] read_byte
);

  logic                           in_full;
  i2cms_pkg::req_item_t           in_item;
  logic                           fire;
  logic                           out_free;
  i2cms_pkg::step_result_t        out_res;
  i2cms_pkg::step_result_t        step_res;
  i2cms_pkg::buf_wr_t             buf_wr;
  logic [i2cms_pkg::ADDR_W-1:0]   buf_rd_addr;
  logic [7:0]                     buf_rd_data;
  logic [7:0]                     buf_first;

  // Flow control: work proceeds when the result register can take a result.
  assign out_free = !out_valid || !out_stall;
  assign fire     = in_full && out_free;
  assign in_stall = in_full && !out_free;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item.req_type   <= req_type;
      in_item.index      <= index;
      in_item.data_byte  <= data_byte;
      in_item.bus_status <= bus_status;
      in_item.mode       <= mode;
      in_item.length     <= length;
    end
  end

  i2cms_buffer u_buffer (
    .clk        (clk),
    .wr         (buf_wr),
    .rd_addr    (buf_rd_addr),
    .rd_data    (buf_rd_data),
    .first_byte (buf_first)
  );

  i2cms_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .item       (in_item),
    .rd_data    (buf_rd_data),
    .first_byte (buf_first),
    .rd_addr    (buf_rd_addr),
    .wr         (buf_wr),
    .result     (step_res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= step_res;
    end
  end

  assign tx_byte        = out_res.tx_byte;
  assign tx_valid       = out_res.tx_valid;
  assign send_start     = out_res.send_start;
  assign send_stop      = out_res.send_stop;
  assign ack_next       = out_res.ack_next;
  assign irq_enabled    = out_res.irq_enabled;
  assign bus_enabled    = out_res.bus_enabled;
  assign transfer_state = out_res.transfer_state;
  assign last_status    = out_res.last_status;
  assign read_byte      = out_res.read_byte;

`ifndef SYNTHESIS
  // Every request taken by the engine shows up in the result register.
  a_fire_to_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("processed request produced no result");

  // A byte to transmit never comes with a start or stop request.
  a_tx_exclusive: assert property (@(posedge clk) disable iff (rst)
    (out_valid && tx_valid) |-> (!send_start && !send_stop))
    else $error("transmit byte coincides with a bus condition");

  // A stalled result holds its value until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_res)))
    else $error("stalled result changed");
`endif

endmodule

[src/i2cms_buffer.sv]
// ----------------------------------------------------------------------------
// I2C master transfer sequencer: byte buffer
// Flip-flop store of the transfer bytes with one write port, one addressed
// read port and a fixed read of the address byte.
// ----------------------------------------------------------------------------
module i2cms_buffer (
  input  logic                          clk,
  input  i2cms_pkg::buf_wr_t            wr,
  input  logic [i2cms_pkg::ADDR_W-1:0]  rd_addr,
  output logic [7:0]                    rd_data,
  output logic [7:0]                    first_byte
);

  logic [7:0] mem [i2cms_pkg::BUFFER_DEPTH];

  // Single write port; contents are undefined until written.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Reads are combinational: the store sits in flip-flops.
  assign rd_data    = mem[rd_addr];
  assign first_byte = mem[0];

endmodule

[src/i2cms_engine.sv]
// ----------------------------------------------------------------------------
// I2C master transfer sequencer: step engine
// Holds the transfer state and works out, in one pass, the effect of one
// request on that state, on the buffer and on the result.
// ----------------------------------------------------------------------------
module i2cms_engine (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         fire,
  input  i2cms_pkg::req_item_t         item,
  input  logic [7:0]                   rd_data,
  input  logic [7:0]                   first_byte,
  output logic [i2cms_pkg::ADDR_W-1:0] rd_addr,
  output i2cms_pkg::buf_wr_t           wr,
  output i2cms_pkg::step_result_t      result
);

  i2cms_pkg::state_t            mode_state, mode_state_next;
  logic [i2cms_pkg::POS_W-1:0]  position, position_next;
  logic [i2cms_pkg::POS_W-1:0]  transfer_length, transfer_length_next;
  logic                         ack_flag, ack_flag_next;
  logic                         irq_flag, irq_flag_next;
  logic                         enable_flag, enable_flag_next;
  logic [7:0]                   status_seen, status_seen_next;

  logic [7:0]                   stat;
  logic                         is_event;
  logic                         idx_ok;
  logic                         pos_full;
  logic                         pos_at_len;
  logic                         autoread_turn;
  logic [i2cms_pkg::POS_W:0]    pos_inc;
  logic [i2cms_pkg::POS_W:0]    len_ext;

  // Shared decode of the current request.
  assign stat          = item.bus_status & i2cms_pkg::STATUS_MASK;
  assign is_event      = (item.req_type == i2cms_pkg::REQ_EVENT) && irq_flag;
  assign idx_ok        = ({{(i2cms_pkg::POS_W+4){1'b0}}, item.index}
                         < (i2cms_pkg::POS_W+8)'(i2cms_pkg::BUFFER_DEPTH));
  assign pos_full      = (position >= i2cms_pkg::POS_DEPTH);
  assign pos_at_len    = (position == transfer_length);
  assign autoread_turn = (mode_state == i2cms_pkg::TS_AUTOREAD)
                         && (position == i2cms_pkg::POS_W'(2));
  assign pos_inc       = {1'b0, position} + (i2cms_pkg::POS_W+1)'(1);
  assign len_ext       = {1'b0, transfer_length};

  // The read port serves read requests, otherwise the transmit position.
  assign rd_addr = (item.req_type == i2cms_pkg::REQ_READ)
                   ? i2cms_pkg::ADDR_W'(item.index)
                   : i2cms_pkg::ADDR_W'(position);

  // Next state and buffer write.
  always_comb begin
    mode_state_next      = mode_state;
    position_next        = position;
    transfer_length_next = transfer_length;
    ack_flag_next        = ack_flag;
    irq_flag_next        = irq_flag;
    enable_flag_next     = enable_flag;
    status_seen_next     = status_seen;
    wr.en                = 1'b0;
    wr.addr              = i2cms_pkg::ADDR_W'(position);
    wr.data              = item.data_byte;

    if (item.req_type == i2cms_pkg::REQ_LOAD) begin
      wr.en   = idx_ok;
      wr.addr = i2cms_pkg::ADDR_W'(item.index);
    end else if (item.req_type == i2cms_pkg::REQ_START) begin
      if (item.mode == i2cms_pkg::MODE_STOP) begin
        mode_state_next = i2cms_pkg::TS_STOP;
      end else if (item.mode == i2cms_pkg::MODE_AUTOREAD) begin
        mode_state_next = i2cms_pkg::TS_AUTOREAD;
      end else begin
        mode_state_next = i2cms_pkg::TS_NOSTOP;
      end
      position_next        = '0;
      transfer_length_next = (item.length > i2cms_pkg::LEN_CAP)
                             ? i2cms_pkg::POS_DEPTH
                             : i2cms_pkg::POS_W'(item.length);
      ack_flag_next        = 1'b0;
      irq_flag_next        = 1'b1;
      enable_flag_next     = 1'b1;
    end else if (is_event) begin
      status_seen_next = stat;
      unique case (stat) inside
        i2cms_pkg::BS_START, i2cms_pkg::BS_RESTART: begin
          position_next = i2cms_pkg::POS_W'(1);
        end
        i2cms_pkg::BS_MT_SLA_ACK, i2cms_pkg::BS_MT_DATA_ACK: begin
          if (autoread_turn) begin
            // Register byte sent: turn the address into a read.
            mode_state_next = i2cms_pkg::TS_STOP;
            wr.en   = 1'b1;
            wr.addr = '0;
            wr.data = first_byte | i2cms_pkg::READ_BIT;
          end else if (pos_at_len) begin
            mode_state_next = i2cms_pkg::TS_IDLE;
          end else if (pos_full) begin
            mode_state_next  = i2cms_pkg::TS_FATAL;
            ack_flag_next    = 1'b0;
            enable_flag_next = 1'b0;
          end else begin
            position_next = pos_inc[i2cms_pkg::POS_W-1:0];
          end
        end
        i2cms_pkg::BS_MT_SLA_NACK, i2cms_pkg::BS_MR_SLA_NACK: begin
          mode_state_next = i2cms_pkg::TS_NAK_ADDR;
        end
        i2cms_pkg::BS_MT_DATA_NACK: begin
          mode_state_next = i2cms_pkg::TS_NAK_DATA;
        end
        i2cms_pkg::BS_ARB_LOST: begin
          mode_state_next = i2cms_pkg::TS_ARB_LOST;
        end
        i2cms_pkg::BS_MR_SLA_ACK: begin
          ack_flag_next = (pos_inc < len_ext);
        end
        i2cms_pkg::BS_MR_DATA_ACK: begin
          if (pos_full) begin
            mode_state_next  = i2cms_pkg::TS_FATAL;
            ack_flag_next    = 1'b0;
            enable_flag_next = 1'b0;
          end else begin
            wr.en         = 1'b1;
            position_next = pos_inc[i2cms_pkg::POS_W-1:0];
            ack_flag_next = ((pos_inc + (i2cms_pkg::POS_W+1)'(1)) < len_ext);
          end
        end
        i2cms_pkg::BS_MR_DATA_NACK: begin
          if (pos_full) begin
            mode_state_next  = i2cms_pkg::TS_FATAL;
            ack_flag_next    = 1'b0;
            enable_flag_next = 1'b0;
          end else begin
            wr.en           = 1'b1;
            position_next   = pos_inc[i2cms_pkg::POS_W-1:0];
            mode_state_next = i2cms_pkg::TS_IDLE;
          end
        end
        default: begin
          // Bus error, no-info and unknown codes all end as fatal.
          irq_flag_next   = 1'b0;
          mode_state_next = i2cms_pkg::TS_FATAL;
        end
      endcase
    end

    // Nothing is written unless the request is really taken.
    wr.en = wr.en && fire;
  end

  // Result outputs for this step.
  always_comb begin
    result                = '0;
    result.ack_next       = ack_flag_next;
    result.irq_enabled    = irq_flag_next;
    result.bus_enabled    = enable_flag_next;
    result.transfer_state = mode_state_next;
    result.last_status    = status_seen_next;

    if (item.req_type == i2cms_pkg::REQ_READ) begin
      result.read_byte = idx_ok ? rd_data : 8'h00;
    end else if (item.req_type == i2cms_pkg::REQ_START) begin
      result.send_start = 1'b1;
    end else if (is_event) begin
      unique case (stat) inside
        i2cms_pkg::BS_START, i2cms_pkg::BS_RESTART: begin
          result.tx_byte  = first_byte;
          result.tx_valid = 1'b1;
        end
        i2cms_pkg::BS_MT_SLA_ACK, i2cms_pkg::BS_MT_DATA_ACK: begin
          if (autoread_turn) begin
            result.send_start = 1'b1;
          end else if (pos_at_len) begin
            result.send_stop = (mode_state == i2cms_pkg::TS_STOP);
          end else if (!pos_full) begin
            result.tx_byte  = rd_data;
            result.tx_valid = 1'b1;
          end
        end
        i2cms_pkg::BS_MT_SLA_NACK, i2cms_pkg::BS_MR_SLA_NACK,
        i2cms_pkg::BS_MT_DATA_NACK: begin
          result.send_stop = 1'b1;
        end
        i2cms_pkg::BS_MR_DATA_NACK: begin
          result.send_stop = !pos_full && (mode_state == i2cms_pkg::TS_STOP);
        end
        default: begin
          result.send_stop = 1'b0;
        end
      endcase
    end
  end

  // State registers, updated only when a request is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_state      <= i2cms_pkg::TS_IDLE;
      position        <= '0;
      transfer_length <= '0;
      ack_flag        <= 1'b0;
      irq_flag        <= 1'b0;
      enable_flag     <= 1'b0;
      status_seen     <= '0;
    end else if (fire) begin
      mode_state      <= mode_state_next;
      position        <= position_next;
      transfer_length <= transfer_length_next;
      ack_flag        <= ack_flag_next;
      irq_flag        <= irq_flag_next;
      enable_flag     <= enable_flag_next;
      status_seen     <= status_seen_next;
    end
  end

`ifndef SYNTHESIS
  // The position never runs past the end of the buffer.
  a_position_bound: assert property (@(posedge clk) disable iff (rst)
    position <= i2cms_pkg::POS_DEPTH)
    else $error("transfer position beyond buffer depth");

  // The stored length is always clamped to the buffer depth.
  a_length_bound: assert property (@(posedge clk) disable iff (rst)
    transfer_length <= i2cms_pkg::POS_DEPTH)
    else $error("transfer length not clamped");

  // A taken start request leaves the transfer armed at its first byte.
  a_start_arms: assert property (@(posedge clk) disable iff (rst)
    (fire && (item.req_type == i2cms_pkg::REQ_START))
    |=> (irq_flag && enable_flag && !ack_flag && (position == '0)))
    else $error("start request did not arm the transfer");
`endif

endmodule

[verif/i2c_master_transfer_sequencer_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// I2C master transfer sequencer: testbench
// Drives load, start, bus status and read requests into the sequencer.
// A behavioural copy of the sequencer works out each expected result, and
// every result taken from the block is compared field by field. A short
// directed table comes first. Random transfer sequences follow, run under
// changing amounts of sender idling and receiver stalling. One long
// receiver hold-off fills the block.
// ----------------------------------------------------------------------------
module i2c_master_transfer_sequencer_core_tb;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS  = 210;
  localparam int HOLD_CYCLES  = 200;

  // Codes that the package leaves unnamed.
  localparam logic [1:0] MODE_NOSTOP     = 2'd0;
  localparam logic [1:0] MODE_NOSTOP_ALT = 2'd3;
  localparam logic [7:0] BS_BUS_ERROR    = 8'h00;
  localparam logic [7:0] BS_NO_INFO      = 8'hF8;
  // Position at which autoread turns the bus round for reading.
  localparam logic [i2cms_pkg::POS_W-1:0] TURN_POS = i2cms_pkg::POS_W'(2);

  typedef struct {
    i2cms_pkg::req_item_t    item;
    bit                      typed;
    i2cms_pkg::step_result_t want;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] req_type;
  logic [3:0] index;
  logic [7:0] data_byte;
  logic [7:0] bus_status;
  logic [1:0] mode;
  logic [7:0] length;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] tx_byte;
  logic       tx_valid;
  logic       send_start;
  logic       send_stop;
  logic       ack_next;
  logic       irq_enabled;
  logic       bus_enabled;
  logic [2:0] transfer_state;
  logic [7:0] last_status;
  logic [7:0] read_byte;

  // Behavioural copy of the sequencer state.
  logic [7:0]                  seq_buf [i2cms_pkg::BUFFER_DEPTH];
  bit                          buf_written [i2cms_pkg::BUFFER_DEPTH];
  logic [i2cms_pkg::POS_W-1:0] seq_pos = '0;
  logic [i2cms_pkg::POS_W-1:0] seq_len = '0;
  i2cms_pkg::state_t           seq_state = i2cms_pkg::TS_IDLE;
  bit                          ack_on = 1'b0;
  bit                          irq_on = 1'b0;
  bit                          bus_on = 1'b0;
  logic [7:0]                  status_last = '0;

  i2cms_pkg::step_result_t pending_results [$];
  i2cms_pkg::step_result_t head_result;
  dir_row_t                directed_rows [$];

  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int hold_request    = 0;
  int hold_left       = 0;
  int cycle_count     = 0;
  int mismatches      = 0;
  int results_checked = 0;
  int worked          = 0;
  int req_count [4]   = '{0, 0, 0, 0};
  int n_overrun       = 0;
  int n_turnaround    = 0;
  int n_fatal         = 0;

  i2c_master_transfer_sequencer_core uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .req_type       (req_type),
    .index          (index),
    .data_byte      (data_byte),
    .bus_status     (bus_status),
    .mode           (mode),
    .length         (length),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .tx_byte        (tx_byte),
    .tx_valid       (tx_valid),
    .send_start     (send_start),
    .send_stop      (send_stop),
    .ack_next       (ack_next),
    .irq_enabled    (irq_enabled),
    .bus_enabled    (bus_enabled),
    .transfer_state (transfer_state),
    .last_status    (last_status),
    .read_byte      (read_byte)
  );

  always #2 clk = ~clk;

  // Buffer overrun: the transfer dies and the bus interface is switched off.
  function automatic void abort_on_overrun();
    seq_state = i2cms_pkg::TS_FATAL;
    ack_on    = 1'b0;
    bus_on    = 1'b0;
    n_overrun++;
  endfunction

  // Moves the sequencer copy on by one request and returns its result.
  function automatic i2cms_pkg::step_result_t step_sequencer(
      input i2cms_pkg::req_item_t it);
    i2cms_pkg::step_result_t r;
    logic [7:0]              code;
    r    = '0;
    code = it.bus_status & i2cms_pkg::STATUS_MASK;
    case (it.req_type)
      i2cms_pkg::REQ_LOAD: begin
        seq_buf[it.index]     = it.data_byte;
        buf_written[it.index] = 1'b1;
      end
      i2cms_pkg::REQ_READ: r.read_byte = seq_buf[it.index];
      i2cms_pkg::REQ_START: begin
        seq_state = (it.mode == i2cms_pkg::MODE_STOP) ? i2cms_pkg::TS_STOP :
                    (it.mode == i2cms_pkg::MODE_AUTOREAD) ? i2cms_pkg::TS_AUTOREAD :
                    i2cms_pkg::TS_NOSTOP;
        seq_pos   = '0;
        seq_len   = (it.length > i2cms_pkg::LEN_CAP) ? i2cms_pkg::POS_DEPTH
                                                     : i2cms_pkg::POS_W'(it.length);
        ack_on    = 1'b0;
        irq_on    = 1'b1;
        bus_on    = 1'b1;
        r.send_start = 1'b1;
      end
      default: begin
        // Bus events are dropped while event handling is off.
        if (irq_on) begin
          status_last = code;
          case (code) inside
            i2cms_pkg::BS_START, i2cms_pkg::BS_RESTART: begin
              r.tx_byte  = seq_buf[0];
              r.tx_valid = 1'b1;
              seq_pos    = i2cms_pkg::POS_W'(1);
            end
            i2cms_pkg::BS_MT_SLA_ACK, i2cms_pkg::BS_MT_DATA_ACK: begin
              if (seq_state == i2cms_pkg::TS_AUTOREAD && seq_pos == TURN_POS) begin
                seq_state    = i2cms_pkg::TS_STOP;
                seq_buf[0]   = seq_buf[0] | i2cms_pkg::READ_BIT;
                r.send_start = 1'b1;
                n_turnaround++;
              end else if (seq_pos == seq_len) begin
                if (seq_state == i2cms_pkg::TS_STOP) r.send_stop = 1'b1;
                seq_state = i2cms_pkg::TS_IDLE;
              end else if (seq_pos >= i2cms_pkg::POS_DEPTH) begin
                abort_on_overrun();
              end else begin
                r.tx_byte  = seq_buf[seq_pos[i2cms_pkg::ADDR_W-1:0]];
                r.tx_valid = 1'b1;
                seq_pos++;
              end
            end
            i2cms_pkg::BS_MT_SLA_NACK, i2cms_pkg::BS_MR_SLA_NACK: begin
              seq_state   = i2cms_pkg::TS_NAK_ADDR;
              r.send_stop = 1'b1;
            end
            i2cms_pkg::BS_MT_DATA_NACK: begin
              seq_state   = i2cms_pkg::TS_NAK_DATA;
              r.send_stop = 1'b1;
            end
            i2cms_pkg::BS_ARB_LOST: seq_state = i2cms_pkg::TS_ARB_LOST;
            i2cms_pkg::BS_MR_SLA_ACK, i2cms_pkg::BS_MR_DATA_ACK: begin
              if (code == i2cms_pkg::BS_MR_DATA_ACK && seq_pos >= i2cms_pkg::POS_DEPTH) begin
                abort_on_overrun();
              end else begin
                if (code == i2cms_pkg::BS_MR_DATA_ACK) begin
                  seq_buf[seq_pos[i2cms_pkg::ADDR_W-1:0]]     = it.data_byte;
                  buf_written[seq_pos[i2cms_pkg::ADDR_W-1:0]] = 1'b1;
                  seq_pos++;
                end
                ack_on = (32'(seq_pos) + 1 < 32'(seq_len));
              end
            end
            i2cms_pkg::BS_MR_DATA_NACK: begin
              if (seq_pos >= i2cms_pkg::POS_DEPTH) begin
                abort_on_overrun();
              end else begin
                seq_buf[seq_pos[i2cms_pkg::ADDR_W-1:0]]     = it.data_byte;
                buf_written[seq_pos[i2cms_pkg::ADDR_W-1:0]] = 1'b1;
                seq_pos++;
                if (seq_state == i2cms_pkg::TS_STOP) r.send_stop = 1'b1;
                seq_state = i2cms_pkg::TS_IDLE;
              end
            end
            default: begin
              irq_on    = 1'b0;
              seq_state = i2cms_pkg::TS_FATAL;
              n_fatal++;
            end
          endcase
        end
      end
    endcase
    r.ack_next       = ack_on;
    r.irq_enabled    = irq_on;
    r.bus_enabled    = bus_on;
    r.transfer_state = seq_state;
    r.last_status    = status_last;
    return r;
  endfunction

  // Result with nothing transmitted and no acknowledge pending.
  function automatic i2cms_pkg::step_result_t plain_result(
      input i2cms_pkg::state_t st, input bit irq_v, input bit bus_v,
      input bit start_v, input bit stop_v, input logic [7:0] status,
      input logic [7:0] rd);
    i2cms_pkg::step_result_t r;
    r                = '0;
    r.transfer_state = st;
    r.irq_enabled    = irq_v;
    r.bus_enabled    = bus_v;
    r.send_start     = start_v;
    r.send_stop      = stop_v;
    r.last_status    = status;
    r.read_byte      = rd;
    return r;
  endfunction

  function automatic void add_row(input logic [1:0] kind, input logic [3:0] idx,
                                  input logic [7:0] dat, input logic [7:0] status,
                                  input logic [1:0] md, input logic [7:0] len,
                                  input bit typed = 1'b0,
                                  input i2cms_pkg::step_result_t want = '0);
    dir_row_t row;
    row.item.req_type   = kind;
    row.item.index      = idx;
    row.item.data_byte  = dat;
    row.item.bus_status = status;
    row.item.mode       = md;
    row.item.length     = len;
    row.typed           = typed;
    row.want            = want;
    directed_rows.push_back(row);
  endfunction

  // Random fields everywhere; the request helpers below override what matters.
  function automatic i2cms_pkg::req_item_t noise_item();
    i2cms_pkg::req_item_t it;
    it.req_type   = 2'($urandom_range(3));
    it.index      = 4'($urandom_range(15));
    it.data_byte  = 8'($urandom_range(255));
    it.bus_status = 8'($urandom_range(255));
    it.mode       = 2'($urandom_range(3));
    it.length     = 8'($urandom_range(255));
    return it;
  endfunction

  function automatic i2cms_pkg::req_item_t load_item(input logic [3:0] idx,
                                                     input logic [7:0] dat);
    i2cms_pkg::req_item_t it;
    it           = noise_item();
    it.req_type  = i2cms_pkg::REQ_LOAD;
    it.index     = idx;
    it.data_byte = dat;
    return it;
  endfunction

  function automatic i2cms_pkg::req_item_t start_item(input logic [1:0] md,
                                                      input logic [7:0] len);
    i2cms_pkg::req_item_t it;
    it          = noise_item();
    it.req_type = i2cms_pkg::REQ_START;
    it.mode     = md;
    it.length   = len;
    return it;
  endfunction

  function automatic i2cms_pkg::req_item_t event_item(input logic [7:0] code);
    i2cms_pkg::req_item_t it;
    it            = noise_item();
    it.req_type   = i2cms_pkg::REQ_EVENT;
    it.bus_status = code | (8'($urandom_range(255)) & ~i2cms_pkg::STATUS_MASK);
    return it;
  endfunction

  function automatic i2cms_pkg::req_item_t read_item(input logic [3:0] idx);
    i2cms_pkg::req_item_t it;
    it          = noise_item();
    it.req_type = i2cms_pkg::REQ_READ;
    it.index    = idx;
    return it;
  endfunction

  // A buffer entry that was never loaded must not be sent or read back:
  // such a request is turned into a load of that entry.
  function automatic i2cms_pkg::req_item_t guard_unwritten(
      input i2cms_pkg::req_item_t it);
    logic [i2cms_pkg::ADDR_W-1:0] need;
    bit                           hazard;
    logic [7:0]                   code;
    code   = it.bus_status & i2cms_pkg::STATUS_MASK;
    need   = '0;
    hazard = 1'b0;
    if (it.req_type == i2cms_pkg::REQ_READ) begin
      need   = it.index;
      hazard = 1'b1;
    end else if (it.req_type == i2cms_pkg::REQ_EVENT && irq_on) begin
      if (code == i2cms_pkg::BS_START || code == i2cms_pkg::BS_RESTART) begin
        hazard = 1'b1;
      end else if (code == i2cms_pkg::BS_MT_SLA_ACK || code == i2cms_pkg::BS_MT_DATA_ACK) begin
        if (seq_state == i2cms_pkg::TS_AUTOREAD && seq_pos == TURN_POS) begin
          hazard = 1'b1;
        end else if (seq_pos != seq_len && seq_pos < i2cms_pkg::POS_DEPTH) begin
          need   = seq_pos[i2cms_pkg::ADDR_W-1:0];
          hazard = 1'b1;
        end
      end
    end
    if (hazard && !buf_written[need]) it = load_item(need, 8'($urandom_range(255)));
    return it;
  endfunction

  // Offers one request, waits for the transfer and records what it must give.
  task automatic transfer_request(input i2cms_pkg::req_item_t it, input bit typed,
                                  input i2cms_pkg::step_result_t want);
    i2cms_pkg::step_result_t r;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    req_type   <= it.req_type;
    index      <= it.index;
    data_byte  <= it.data_byte;
    bus_status <= it.bus_status;
    mode       <= it.mode;
    length     <= it.length;
    do @(posedge clk); while (in_stall);
    if (!(it.req_type == i2cms_pkg::REQ_EVENT && !irq_on)) worked++;
    req_count[it.req_type]++;
    r = step_sequencer(it);
    pending_results.push_back(typed ? want : r);
  endtask

  task automatic issue(input i2cms_pkg::req_item_t it);
    transfer_request(guard_unwritten(it), 1'b0, i2cms_pkg::step_result_t'(0));
  endtask

  // One random bus transaction, mostly well formed, sometimes broken or noise.
  task automatic random_sequence();
    int         kind;
    int         len;
    int         n;
    int         fault;
    logic [1:0] md;
    kind = $urandom_range(99);
    len  = ($urandom_range(9) == 0) ? $urandom_range(255)
                                    : $urandom_range(1, i2cms_pkg::BUFFER_DEPTH);
    n    = (len > i2cms_pkg::BUFFER_DEPTH) ? i2cms_pkg::BUFFER_DEPTH : len;
    md   = ($urandom_range(3) == 0) ? MODE_NOSTOP_ALT :
           ($urandom_range(1) == 1) ? i2cms_pkg::MODE_STOP : MODE_NOSTOP;
    if (kind < 50) begin
      // Write: address and data bytes out, with the odd NAK or lost arbitration.
      for (int i = 0; i < n; i++)
        if (!buf_written[i] || $urandom_range(1) == 1)
          issue(load_item(4'(i), 8'($urandom_range(255))));
      issue(start_item(md, 8'(len)));
      issue(event_item(($urandom_range(4) == 0) ? i2cms_pkg::BS_RESTART
                                                : i2cms_pkg::BS_START));
      for (int i = 1; i <= n; i++) begin
        fault = $urandom_range(29);
        if (fault == 0) begin
          issue(event_item((i == 1) ? i2cms_pkg::BS_MT_SLA_NACK
                                    : i2cms_pkg::BS_MT_DATA_NACK));
          break;
        end
        if (fault == 1) begin
          issue(event_item(i2cms_pkg::BS_ARB_LOST));
          break;
        end
        issue(event_item((i == 1) ? i2cms_pkg::BS_MT_SLA_ACK
                                  : i2cms_pkg::BS_MT_DATA_ACK));
      end
    end else if (kind < 70) begin
      // Read: address out, bytes in, then some of them read back.
      issue(load_item(4'd0, 8'($urandom_range(255))));
      issue(start_item(md, 8'(len)));
      issue(event_item(i2cms_pkg::BS_START));
      if ($urandom_range(9) == 0) begin
        issue(event_item(i2cms_pkg::BS_MR_SLA_NACK));
      end else begin
        issue(event_item(i2cms_pkg::BS_MR_SLA_ACK));
        for (int i = 1; i < n - 1; i++) issue(event_item(i2cms_pkg::BS_MR_DATA_ACK));
        issue(event_item(i2cms_pkg::BS_MR_DATA_NACK));
        repeat ($urandom_range(1, 3))
          issue(read_item(4'($urandom_range((n > 0) ? n - 1 : 0))));
      end
    end else if (kind < 80) begin
      // Autoread: register byte out, repeated start, then bytes in.
      n = $urandom_range(2, i2cms_pkg::BUFFER_DEPTH);
      issue(load_item(4'd0, 8'($urandom_range(255))));
      issue(load_item(4'd1, 8'($urandom_range(255))));
      issue(start_item(i2cms_pkg::MODE_AUTOREAD, 8'(n)));
      issue(event_item(i2cms_pkg::BS_START));
      issue(event_item(i2cms_pkg::BS_MT_SLA_ACK));
      issue(event_item(i2cms_pkg::BS_MT_DATA_ACK));
      issue(event_item(i2cms_pkg::BS_RESTART));
      issue(event_item(i2cms_pkg::BS_MR_SLA_ACK));
      for (int i = 1; i < n - 1; i++) issue(event_item(i2cms_pkg::BS_MR_DATA_ACK));
      issue(event_item(i2cms_pkg::BS_MR_DATA_NACK));
      issue(read_item(4'd0));
    end else if (kind < 88) begin
      // Overrun: run past the end of the buffer, sending or receiving.
      if ($urandom_range(1) == 1) begin
        issue(start_item(md, 8'd0));
        issue(event_item(i2cms_pkg::BS_START));
        repeat (i2cms_pkg::BUFFER_DEPTH + 2) issue(event_item(i2cms_pkg::BS_MT_DATA_ACK));
      end else begin
        issue(start_item(md, 8'($urandom_range(i2cms_pkg::BUFFER_DEPTH - 1))));
        issue(event_item(i2cms_pkg::BS_START));
        issue(event_item(i2cms_pkg::BS_MR_SLA_ACK));
        repeat (i2cms_pkg::BUFFER_DEPTH + 1) issue(event_item(i2cms_pkg::BS_MR_DATA_ACK));
      end
    end else begin
      repeat ($urandom_range(1, 6)) issue(noise_item());
    end
  endtask

  function automatic void note_field(input string name, input logic [31:0] want,
                                     input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endfunction

  // Result side: check each accepted transfer, then choose the next stall.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: result with none expected", $time);
      end else begin
        head_result = pending_results.pop_front();
        note_field("tx_byte", 32'(head_result.tx_byte), 32'(tx_byte));
        note_field("tx_valid", 32'(head_result.tx_valid), 32'(tx_valid));
        note_field("send_start", 32'(head_result.send_start), 32'(send_start));
        note_field("send_stop", 32'(head_result.send_stop), 32'(send_stop));
        note_field("ack_next", 32'(head_result.ack_next), 32'(ack_next));
        note_field("irq_enabled", 32'(head_result.irq_enabled), 32'(irq_enabled));
        note_field("bus_enabled", 32'(head_result.bus_enabled), 32'(bus_enabled));
        note_field("transfer_state", 32'(head_result.transfer_state),
                   32'(transfer_state));
        note_field("last_status", 32'(head_result.last_status), 32'(last_status));
        note_field("read_byte", 32'(head_result.read_byte), 32'(read_byte));
        results_checked++;
      end
    end
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("i2c_master_transfer_sequencer_core: mismatch");
      $finish;
    end
  end

  // Directed table, then random phases, then drain and verdict.
  initial begin
    int phase_start;
    rst        = 1'b1;
    in_valid   = 1'b0;
    req_type   = i2cms_pkg::REQ_LOAD;
    index      = '0;
    data_byte  = '0;
    bus_status = '0;
    mode       = MODE_NOSTOP;
    length     = '0;

    // Event before any start is dropped; buffer loads and read-back at the extremes.
    add_row(i2cms_pkg::REQ_EVENT, 4'd0, 8'h00, BS_NO_INFO | ~i2cms_pkg::STATUS_MASK,
            MODE_NOSTOP, 8'd0, 1'b1,
            plain_result(i2cms_pkg::TS_IDLE, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00));
    add_row(i2cms_pkg::REQ_LOAD, 4'd0, 8'hA4, BS_BUS_ERROR, MODE_NOSTOP, 8'd0);
    add_row(i2cms_pkg::REQ_LOAD, 4'd15, 8'hFF, BS_BUS_ERROR, MODE_NOSTOP, 8'd0);
    add_row(i2cms_pkg::REQ_READ, 4'd15, 8'h00, BS_BUS_ERROR, MODE_NOSTOP, 8'd0, 1'b1,
            plain_result(i2cms_pkg::TS_IDLE, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 8'hFF));
    add_row(i2cms_pkg::REQ_LOAD, 4'd1, 8'h00, BS_BUS_ERROR, MODE_NOSTOP, 8'd0);
    add_row(i2cms_pkg::REQ_LOAD, 4'd2, 8'h5A, BS_BUS_ERROR, MODE_NOSTOP, 8'd0);
    // Write with stop, length clamped to the buffer, ending in a data NAK.
    add_row(i2cms_pkg::REQ_START, 4'd0, 8'h00, BS_BUS_ERROR, i2cms_pkg::MODE_STOP,
            8'hFF, 1'b1,
            plain_result(i2cms_pkg::TS_STOP, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 8'h00));
    add_row(i2cms_pkg::REQ_EVENT, 4'd0, 8'h00,
            i2cms_pkg::BS_START | ~i2cms_pkg::STATUS_MASK, MODE_NOSTOP, 8'd0);
    add_row(i2cms_pkg::REQ_EVENT, 4'd0, 8'h00, i2cms_pkg::BS_MT_SLA_ACK, MODE_NOSTOP,
            8'd0);
    add_row(i2cms_pkg::REQ_EVENT, 4'd0, 8'h00, i2cms_pkg::BS_MT_DATA_ACK, MODE_NOSTOP,
            8'd0);
    add_row(i2cms_pkg::REQ_EVENT, 4'd0, 8'h00, i2cms_pkg::BS_MT_DATA_NACK, MODE_NOSTOP,
            8'd0, 1'b1,
            plain_result(i2cms_pkg::TS_NAK_DATA, 1'b1, 1'b1, 1'b0, 1'b1,
                         i2cms_pkg::BS_MT_DATA_NACK, 8'h00));
    // Mode three with zero length: received bytes are never acknowledged.
    add_row(i2cms_pkg::REQ_START, 4'd0, 8'h00, BS_BUS_ERROR, MODE_NOSTOP_ALT, 8'd0);
    add_row(i2cms_pkg::REQ_EVENT, 4'd0, 8'h00, i2cms_pkg::BS_RESTART, MODE_NOSTOP, 8'd0);
    add_row(i2cms_pkg::REQ_EVENT, 4'd0, 8'h00, i2cms_pkg::BS_MR_SLA_ACK, MODE_NOSTOP,
            8'd0);
    add_row(i2cms_pkg::REQ_EVENT, 4'd0, 8'h3C, i2cms_pkg::BS_MR_DATA_ACK, MODE_NOSTOP,
            8'd0);
    add_row(i2cms_pkg::REQ_EVENT, 4'd0, 8'hC3, i2cms_pkg::BS_MR_DATA_NACK, MODE_NOSTOP,
            8'd0);
    // Lost arbitration and both address NAK codes.
    add_row(i2cms_pkg::REQ_EVENT, 4'd0, 8'h00, i2cms_pkg::BS_ARB_LOST, MODE_NOSTOP,
            8'd0, 1'b1,
            plain_result(i2cms_pkg::TS_ARB_LOST, 1'b1, 1'b1, 1'b0, 1'b0,
                         i2cms_pkg::BS_ARB_LOST, 8'h00));
    add_row(i2cms_pkg::REQ_EVENT, 4'd0, 8'h00, i2cms_pkg::BS_MT_SLA_NACK, MODE_NOSTOP,
            8'd0);
    add_row(i2cms_pkg::REQ_EVENT, 4'd0, 8'h00, i2cms_pkg::BS_MR_SLA_NACK, MODE_NOSTOP,
            8'd0);
    // Autoread turn-round sets the read bit, then a bus error is fatal.
    add_row(i2cms_pkg::REQ_START, 4'd0, 8'h00, BS_BUS_ERROR, i2cms_pkg::MODE_AUTOREAD,
            8'd3);
    add_row(i2cms_pkg::REQ_EVENT, 4'd0, 8'h00, i2cms_pkg::BS_START, MODE_NOSTOP, 8'd0);
    add_row(i2cms_pkg::REQ_EVENT, 4'd0, 8'h00, i2cms_pkg::BS_MT_SLA_ACK, MODE_NOSTOP,
            8'd0);
    add_row(i2cms_pkg::REQ_EVENT, 4'd0, 8'h00, i2cms_pkg::BS_MT_DATA_ACK, MODE_NOSTOP,
            8'd0);
    add_row(i2cms_pkg::REQ_EVENT, 4'd0, 8'h00, i2cms_pkg::BS_RESTART, MODE_NOSTOP, 8'd0);
    add_row(i2cms_pkg::REQ_EVENT, 4'd0, 8'h00, BS_BUS_ERROR, MODE_NOSTOP, 8'd0, 1'b1,
            plain_result(i2cms_pkg::TS_FATAL, 1'b0, 1'b1, 1'b0, 1'b0, BS_BUS_ERROR,
                         8'h00));
    add_row(i2cms_pkg::REQ_EVENT, 4'd0, 8'h00, BS_NO_INFO, MODE_NOSTOP, 8'd0);
    add_row(i2cms_pkg::REQ_READ, 4'd0, 8'h00, BS_BUS_ERROR, MODE_NOSTOP, 8'd0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      transfer_request(directed_rows[i].item, directed_rows[i].typed,
                       directed_rows[i].want);

    // Random phases: free running, sender idling, receiver stalling, both.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          sender_idle_pct = 0;
          recv_stall_pct  = 0;
          hold_request    = HOLD_CYCLES;
        end
        1: begin
          sender_idle_pct = 58;
          recv_stall_pct  = 0;
        end
        2: begin
          sender_idle_pct = 0;
          recv_stall_pct  = 58;
        end
        default: begin
          sender_idle_pct = 18;
          recv_stall_pct  = 18;
        end
      endcase
      phase_start = worked;
      while (worked - phase_start < PHASE_ITEMS) random_sequence();
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d loads, %0d starts, %0d bus events and %0d reads; %0d checked.",
             req_count[i2cms_pkg::REQ_LOAD], req_count[i2cms_pkg::REQ_START],
             req_count[i2cms_pkg::REQ_EVENT], req_count[i2cms_pkg::REQ_READ],
             results_checked);
    $display("Seen %0d buffer overruns, %0d autoread turn-rounds, %0d fatal status codes.",
             n_overrun, n_turnaround, n_fatal);
    if (mismatches == 0) begin
      $display("i2c_master_transfer_sequencer_core: match");
    end else begin
      $display("i2c_master_transfer_sequencer_core: mismatch");
    end
    $finish;
  end

endmodule
